// File: sv/clni_pkg.sv
// Shared types, codes and constants of the character LCD nibble interface.
// No dependencies; every other file of the block imports this package.
package clni_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINES   = 2'd1;
   localparam logic [5:0] COLUMNS_RESET = 6'd16;
   localparam logic [1:0] LINES_RESET   = 2'd2;

   // request modes
   localparam logic [3:0] MODE_INIT         = 4'd0;
   localparam logic [3:0] MODE_PUT_CHAR     = 4'd1;
   localparam logic [3:0] MODE_SET_CURSOR   = 4'd2;
   localparam logic [3:0] MODE_DISPLAY      = 4'd3;
   localparam logic [3:0] MODE_SCROLL_LEFT  = 4'd4;
   localparam logic [3:0] MODE_SCROLL_RIGHT = 4'd5;
   localparam logic [3:0] MODE_CLEAR        = 4'd6;
   localparam logic [3:0] MODE_GLYPH        = 4'd7;
   localparam logic [3:0] MODE_RAW          = 4'd8;

   // wait after strobe
   localparam logic [1:0] WAIT_40US  = 2'd0;
   localparam logic [1:0] WAIT_100US = 2'd1;
   localparam logic [1:0] WAIT_3MS   = 2'd2;
   localparam logic [1:0] WAIT_4MS5  = 2'd3;

   // controller commands
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_DISPLAY     = 8'h08;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
   localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
   localparam logic [7:0] CMD_FUNC_1LINE  = 8'h20;
   localparam logic [7:0] CMD_FUNC_2LINE  = 8'h28;
   localparam logic [7:0] CMD_SET_CGRAM   = 8'h40;
   localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
   localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
   localparam logic [3:0] BUS4_NIBBLE     = 4'h2;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam int INIT_NIBBLES = 12;
   localparam int STEP_W       = $clog2(INIT_NIBBLES);

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] value;
      logic [5:0] col;
      logic [1:0] row;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic [1:0] wait_class;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic [1:0] wait_class;
   } nib_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] data;
      logic [1:0] wait_class;
   } byte_type;

   // one queued job: the init sequence, or one or two bytes
   typedef struct packed {
      logic     is_init;
      logic     two_line;
      logic     two_bytes;
      byte_type first;
      byte_type second;
   } job_type;

   function automatic byte_type cmd_byte(input logic [7:0] data, input logic [1:0] wait_class);
      byte_type b;
      b.reg_select = 1'b0;
      b.data       = data;
      b.wait_class = wait_class;
      return b;
   endfunction

   function automatic byte_type data_byte(input logic [7:0] data);
      byte_type b;
      b.reg_select = 1'b1;
      b.data       = data;
      b.wait_class = WAIT_40US;
      return b;
   endfunction

   function automatic byte_type set_cursor_byte(input logic [6:0] col, input logic line);
      logic [6:0] addr;
      addr = col + {line, 6'b0};
      return cmd_byte(CMD_SET_DDRAM | {1'b0, addr}, WAIT_40US);
   endfunction

   // init sequence, one nibble per step
   function automatic nib_type init_nibble(input logic [STEP_W-1:0] step, input logic two_line);
      nib_type    n;
      logic [7:0] func;
      func         = two_line ? CMD_FUNC_2LINE : CMD_FUNC_1LINE;
      n.reg_select = 1'b0;
      n.nibble     = 4'h0;
      n.wait_class = WAIT_40US;
      case (step)
         4'd0, 4'd1, 4'd2: begin
            n.nibble     = WAKE_NIBBLE;
            n.wait_class = WAIT_4MS5;
         end
         4'd3: begin
            n.nibble     = BUS4_NIBBLE;
            n.wait_class = WAIT_100US;
         end
         4'd4:  n.nibble = func[7:4];
         4'd5:  n.nibble = func[3:0];
         4'd6:  n.nibble = CMD_DISPLAY_ON[7:4];
         4'd7:  n.nibble = CMD_DISPLAY_ON[3:0];
         4'd8:  n.nibble = CMD_CLEAR[7:4];
         4'd9: begin
            n.nibble     = CMD_CLEAR[3:0];
            n.wait_class = WAIT_3MS;
         end
         4'd10: n.nibble = CMD_ENTRY_MODE[7:4];
         4'd11: begin
            n.nibble     = CMD_ENTRY_MODE[3:0];
            n.wait_class = WAIT_4MS5;
         end
         default: n.nibble = 4'h0;
      endcase
      return n;
   endfunction

endpackage

// File: sv/char_lcd_nibble_interface.sv
// Top level of the character LCD nibble interface (4-bit bus controller).
// Depends on clni_pkg, clni_front, clni_queue and clni_back.
//
// Usage:
//  - req_*: one request item per handshake (mode, value, col, row). Unknown
//    modes are accepted and dropped. req_ready is high while the job queue
//    has room, so a request can be taken every cycle until it fills.
//  - rsp_*: one item per bus transfer: reg_select, nibble (high half of a
//    byte first), wait_class for the pin driver, last on the final nibble
//    of a request.
//  - csr_*: register writes (0 columns, 1 lines); csr_ready is always high.
//    Other indexes are ignored. Write only while no request is in flight.
// Flow:
//  - an accepted request goes into the job queue, then the back end's job
//    register, then nibble by nibble the output register, one nibble per
//    cycle while that register can load (empty, or rsp_ready high).
//  - nibbles per request: 2 for a plain command or character, 4 for a
//    character that wraps, 12 for init, all from the single sequencer.
// Reset: clears the queue, the sequencer, the output valid flag and the
//  cursor; columns returns to 16 and lines to 2.
// Stall: when rsp_ready is low the output holds, the sequencer waits, and
//  requests keep filling the queue until it is full.
module char_lcd_nibble_interface #(
   parameter int QUEUE_DEPTH = clni_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  clni_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output clni_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [clni_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [clni_pkg::CSR_DATA_W-1:0]   csr_data
);
   import clni_pkg::*;

   logic    accept, push, full, pop, empty;
   job_type job_new, job_head;

   assign csr_ready = 1'b1;
   assign req_ready = ~full;
   assign accept    = req_valid & req_ready;

   // classification and cursor bookkeeping happen at acceptance
   clni_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .job       (job_new)
   );

   clni_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job_new),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (job_head)
   );

   // nibble sequencer with registered output
   clni_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (~empty),
      .job       (job_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/clni_front.sv
// Front end: configuration registers, cursor tracking, request classification.
// Depends on clni_pkg.
module clni_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  clni_pkg::req_type                    req_data,
   input  logic                                 csr_write,
   input  logic [clni_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [clni_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 push,
   output clni_pkg::job_type                    job
);
   import clni_pkg::*;

   logic [5:0] columns_ff, columns_in;
   logic [1:0] lines_ff, lines_in;
   logic [6:0] col_ff, col_in;
   logic       line_ff, line_in;
   logic       known;

   logic       two_line, wrap, line_w, lf_line, cr_line, sc_line;
   logic [6:0] col_w;
   byte_type   main_byte;

   assign two_line = lines_ff[1];
   assign wrap     = col_ff >= {1'b0, columns_ff};
   assign col_w    = wrap ? 7'd0 : col_ff;
   assign line_w   = wrap ? (two_line & ~line_ff) : line_ff;
   assign lf_line  = two_line & ~line_w;
   assign cr_line  = two_line & line_w;
   assign sc_line  = two_line & (req_data.row == 2'd1);

   always_comb begin
      columns_in = columns_ff;
      lines_in   = lines_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COLUMNS: columns_in = csr_data;
            CSR_LINES:   lines_in   = csr_data[1:0];
            default:     columns_in = columns_ff;
         endcase
      end
   end

   always_comb begin
      col_in        = col_ff;
      line_in       = line_ff;
      known         = 1'b1;
      main_byte     = data_byte(req_data.value);
      job           = '0;
      job.two_line  = two_line;
      case (req_data.mode)
         MODE_INIT: begin
            job.is_init = 1'b1;
            col_in      = 7'd0;
            line_in     = 1'b0;
         end
         MODE_PUT_CHAR: begin
            if (req_data.value == CHAR_LF) begin
               main_byte = set_cursor_byte(col_w, lf_line);
               col_in    = col_w;
               line_in   = lf_line;
            end else if (req_data.value == CHAR_CR) begin
               main_byte = set_cursor_byte(7'd0, cr_line);
               col_in    = 7'd0;
               line_in   = cr_line;
            end else begin
               main_byte = data_byte(req_data.value);
               col_in    = col_w + 7'd1;
               line_in   = line_w;
            end
            job.two_bytes = wrap;
            job.first     = wrap ? set_cursor_byte(7'd0, line_w) : main_byte;
            job.second    = main_byte;
         end
         MODE_SET_CURSOR: begin
            job.first = set_cursor_byte({1'b0, req_data.col}, sc_line);
            col_in    = {1'b0, req_data.col};
            line_in   = sc_line;
         end
         MODE_DISPLAY:
            job.first = cmd_byte(CMD_DISPLAY | {5'b0, req_data.value[2:0]}, WAIT_40US);
         MODE_SCROLL_LEFT:  job.first = cmd_byte(CMD_SHIFT_LEFT, WAIT_40US);
         MODE_SCROLL_RIGHT: job.first = cmd_byte(CMD_SHIFT_RIGHT, WAIT_40US);
         MODE_CLEAR: begin
            job.first = cmd_byte(CMD_CLEAR, WAIT_3MS);
            col_in    = 7'd0;
            line_in   = 1'b0;
         end
         MODE_GLYPH:
            job.first = cmd_byte(CMD_SET_CGRAM | {2'b0, req_data.value[2:0], 3'b0}, WAIT_40US);
         MODE_RAW: job.first = data_byte(req_data.value);
         default:  known = 1'b0;
      endcase
   end

   assign push = accept & known;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         lines_ff   <= LINES_RESET;
         col_ff     <= 7'd0;
         line_ff    <= 1'b0;
      end else begin
         columns_ff <= columns_in;
         lines_ff   <= lines_in;
         if (accept) begin
            col_ff  <= col_in;
            line_ff <= line_in;
         end
      end
   end

endmodule

// File: sv/clni_queue.sv
// Job queue between front and back end, DEPTH entries, first in first out.
// Depends on clni_pkg.
module clni_queue #(
   parameter int DEPTH = clni_pkg::QUEUE_DEPTH_DEFAULT  // at least 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clni_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output clni_pkg::job_type head
);
   import clni_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/clni_back.sv
// Back end: one job nibble per cycle into the output register unless stalled.
// Depends on clni_pkg.
module clni_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  clni_pkg::job_type job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output clni_pkg::rsp_type rsp_data
);
   import clni_pkg::*;

   localparam logic [STEP_W-1:0] LAST_INIT_STEP = STEP_W'(INIT_NIBBLES - 1);

   logic              busy_ff, busy_in;
   job_type           job_ff, job_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   nib_type  nib;
   byte_type sel;
   logic     is_last, out_load, advance;

   always_comb begin
      sel = step_ff[1] ? job_ff.second : job_ff.first;
      if (job_ff.is_init) begin
         nib     = init_nibble(step_ff, job_ff.two_line);
         is_last = step_ff == LAST_INIT_STEP;
      end else begin
         nib.reg_select = sel.reg_select;
         nib.nibble     = step_ff[0] ? sel.data[3:0] : sel.data[7:4];
         nib.wait_class = step_ff[0] ? sel.wait_class : WAIT_40US;
         is_last        = step_ff[0] & (step_ff[1] | ~job_ff.two_bytes);
      end
   end

   assign out_load = ~rsp_valid_ff | rsp_ready;
   assign advance  = busy_ff & out_load;
   // next job enters in the cycle the current one hands over its last nibble
   assign pop      = job_valid & (~busy_ff | (advance & is_last));

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      job_in       = job_ff;
      rsp_valid_in = out_load ? busy_ff : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_in  = '{reg_select: nib.reg_select, nibble: nib.nibble,
                     wait_class: nib.wait_class, last: is_last};
         step_in = step_ff + 1'b1;
         if (is_last)
            busy_in = 1'b0;
      end
      if (pop) begin
         busy_in = 1'b1;
         step_in = '0;
         job_in  = job;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/clni_checker.sv
// Port-level checks of the character LCD nibble interface, bound to the top.
// Depends on clni_pkg and char_lcd_nibble_interface.
module clni_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input clni_pkg::rsp_type rsp_data
);
   import clni_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_data_short_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reg_select |-> rsp_data.wait_class == WAIT_40US)
      else $error("data nibble with long wait");

   a_bus4_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wait_class == WAIT_100US |->
         !rsp_data.last && !rsp_data.reg_select && rsp_data.nibble == BUS4_NIBBLE)
      else $error("4-bit switch nibble out of place");

endmodule

bind char_lcd_nibble_interface clni_checker u_clni_checker (.*);
